// ===== rtl/cdad_pkg.sv =====
// ----------------------------------------------------------------------------
// cdad_pkg: shared constants, types and calendar functions
// Month lengths, the Gregorian leap rule and the date context record used
// between the front end, the queue and the month roller.
// ----------------------------------------------------------------------------
package cdad_pkg;

  localparam int DAY_W           = 5;
  localparam int MONTH_W         = 4;
  localparam int YEAR_W          = 14;
  localparam int MOD100_W        = 7;
  localparam int CENT_W          = 7;
  localparam int OFFSET_BITS_DEF = 13;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [YEAR_W-1:0]   YEAR_MAX    = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]   YEAR_MIN    = '0;
  localparam logic [MOD100_W-1:0] MOD100_LAST = MOD100_W'(99);

  // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every y up to 9999
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [DAY_W-1:0] DAY_FIRST = DAY_W'(1);
  localparam logic [DAY_W-1:0] DAY_LAST  = DAY_W'(31);

  // Month, year and the year's position in the 400-year cycle
  typedef struct packed {
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [MOD100_W-1:0] ymod100;  // year mod 100
    logic [1:0]          cmod4;    // (year / 100) mod 4
  } cdad_date_t;

  function automatic logic is_leap(input logic [MOD100_W-1:0] ymod100,
                                   input logic [1:0] cmod4);
    logic leap;
    if (ymod100 == '0) begin
      leap = (cmod4 == 2'd0);
    end else begin
      leap = (ymod100[1:0] == 2'd0);
    end
    return leap;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = DAY_W'(30);
    end else if (m == MONTH_FEB) begin
      len = leap ? DAY_W'(29) : DAY_W'(28);
    end else begin
      len = DAY_W'(31);
    end
    return len;
  endfunction

endpackage

// ===== rtl/cdad_front.sv =====
// ----------------------------------------------------------------------------
// cdad_front: request intake and date correction
// Clamp month, year and day into range, place the year in the 400-year cycle
// and add the offset to the day, then hand the request to the queue.
// ----------------------------------------------------------------------------
module cdad_front #(
  parameter int OFFSET_BITS = cdad_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cdad_pkg::DAY_W-1:0]        day_in,
  input  logic [cdad_pkg::MONTH_W-1:0]      month_in,
  input  logic [cdad_pkg::YEAR_W-1:0]       year_in,
  input  logic signed [OFFSET_BITS-1:0]     day_offset,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cdad_pkg::cdad_date_t              out_date,
  output logic signed [OFFSET_BITS:0]       out_day
);
  import cdad_pkg::*;

  localparam int DW     = OFFSET_BITS + 1;
  localparam int PROD_W = YEAR_W + RECIP_W;

  // stage 1: request with month and year clamped, and century
  logic                          s1_valid;
  logic [DAY_W-1:0]              s1_day;
  logic [MONTH_W-1:0]            s1_month;
  logic [YEAR_W-1:0]             s1_year;
  logic signed [OFFSET_BITS-1:0] s1_off;
  logic [CENT_W-1:0]             s1_cent;

  logic [MONTH_W-1:0] month_c;
  logic [YEAR_W-1:0]  year_c;
  logic [PROD_W-1:0]  cent_prod;

  logic [YEAR_W-1:0]   cent100;
  logic [YEAR_W-1:0]   rem100;
  logic [MOD100_W-1:0] ymod100;
  logic                leap;
  logic [DAY_W-1:0]    len;
  logic [DAY_W-1:0]    day_c;

  always_comb begin
    if (month_in == '0) begin
      month_c = MONTH_JAN;
    end else if (month_in > MONTH_DEC) begin
      month_c = MONTH_DEC;
    end else begin
      month_c = month_in;
    end
    year_c    = (year_in > YEAR_MAX) ? YEAR_MAX : year_in;
    cent_prod = PROD_W'(year_c) * PROD_W'(RECIP_100);
  end

  assign in_ready = !s1_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_day   <= day_in;
      s1_month <= month_c;
      s1_year  <= year_c;
      s1_off   <= day_offset;
      s1_cent  <= cent_prod[RECIP_SHIFT +: CENT_W];
    end
  end

  // stage 2: leap status, day clamp, offset add
  always_comb begin
    cent100 = YEAR_W'(s1_cent) * YEAR_W'(100);
    rem100  = s1_year - cent100;
    ymod100 = rem100[MOD100_W-1:0];
    leap    = is_leap(ymod100, s1_cent[1:0]);
    len     = month_len(s1_month, leap);
    if (s1_day == '0) begin
      day_c = DAY_FIRST;
    end else if (s1_day > len) begin
      day_c = len;
    end else begin
      day_c = s1_day;
    end
  end

  assign out_valid        = s1_valid;
  assign out_date.month   = s1_month;
  assign out_date.year    = s1_year;
  assign out_date.ymod100 = ymod100;
  assign out_date.cmod4   = s1_cent[1:0];
  assign out_day = DW'(s1_off) + signed'({{(DW-DAY_W){1'b0}}, day_c});

endmodule

// ===== rtl/cdad_queue.sv =====
// ----------------------------------------------------------------------------
// cdad_queue: short request queue
// Small register FIFO between the front end and the month roller.
// ----------------------------------------------------------------------------
module cdad_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cdad_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  import cdad_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/cdad_roller.sv =====
// ----------------------------------------------------------------------------
// cdad_roller: month-by-month date roller
// Take one request from the queue, carry the day count across one month per
// cycle forward or back, saturate at the year range ends, register result.
// ----------------------------------------------------------------------------
module cdad_roller #(
  parameter int OFFSET_BITS = cdad_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  cdad_pkg::cdad_date_t         q_date,
  input  logic signed [OFFSET_BITS:0]  q_day,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [cdad_pkg::DAY_W-1:0]   day_out,
  output logic [cdad_pkg::MONTH_W-1:0] month_out,
  output logic [cdad_pkg::YEAR_W-1:0]  year_out,
  output logic                         year_overflow
);
  import cdad_pkg::*;

  localparam int DW = OFFSET_BITS + 1;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                state;
  logic signed [DW-1:0]  d;
  cdad_date_t            dt;
  logic                  ovf;

  logic                  leap;
  logic [DAY_W-1:0]      len;
  logic [DAY_W-1:0]      prev_len;
  logic                  fwd;
  logic                  bwd;
  logic                  done;
  logic                  emit;

  always_comb begin
    leap     = is_leap(dt.ymod100, dt.cmod4);
    len      = month_len(dt.month, leap);
    prev_len = (dt.month == MONTH_JAN) ? DAY_LAST : month_len(dt.month - 1'b1, leap);
    fwd      = d > signed'({{(DW-DAY_W){1'b0}}, len});
    bwd      = d[DW-1] || (d == '0);
    done     = !fwd && !bwd;
    emit     = (state == ST_RUN) && done && (!res_valid || res_ready);
  end

  assign q_pop = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            d     <= q_day;
            dt    <= q_date;
            ovf   <= 1'b0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (done) begin
            // hold here until the result register frees up
            if (emit) begin
              day_out       <= d[DAY_W-1:0];
              month_out     <= dt.month;
              year_out      <= dt.year;
              year_overflow <= ovf;
              state         <= ST_IDLE;
            end
          end else if (fwd) begin
            if (dt.month == MONTH_DEC && dt.year == YEAR_MAX) begin
              d        <= DW'(DAY_LAST);
              ovf      <= 1'b1;
            end else if (dt.month == MONTH_DEC) begin
              d        <= d - DW'(len);
              dt.month <= MONTH_JAN;
              dt.year  <= dt.year + 1'b1;
              if (dt.ymod100 == MOD100_LAST) begin
                dt.ymod100 <= '0;
                dt.cmod4   <= dt.cmod4 + 1'b1;
              end else begin
                dt.ymod100 <= dt.ymod100 + 1'b1;
              end
            end else begin
              d        <= d - DW'(len);
              dt.month <= dt.month + 1'b1;
            end
          end else begin
            if (dt.month == MONTH_JAN && dt.year == YEAR_MIN) begin
              d        <= DW'(DAY_FIRST);
              ovf      <= 1'b1;
            end else if (dt.month == MONTH_JAN) begin
              d        <= d + DW'(DAY_LAST);
              dt.month <= MONTH_DEC;
              dt.year  <= dt.year - 1'b1;
              if (dt.ymod100 == '0) begin
                dt.ymod100 <= MOD100_LAST;
                dt.cmod4   <= dt.cmod4 - 1'b1;
              end else begin
                dt.ymod100 <= dt.ymod100 - 1'b1;
              end
            end else begin
              d        <= d + DW'(prev_len);
              dt.month <= dt.month - 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/calendar_date_add_days_unit.sv =====
// The month roller works on one request at a time and crosses one month boundary
//   per cycle, a step that saturates the year taking the place of a crossing.
// The front end accepts while the roller works; a two-entry queue parts them.
// Reset: synchronous, active high; clears handshake state, queue and roller.
// ----------------------------------------------------------------------------
// calendar_date_add_days_unit: Gregorian date plus signed day offset
// Corrects the starting date into range, then rolls months and years with the
// Gregorian leap rule; a year leaving 0..9999 saturates and raises a flag.
// ----------------------------------------------------------------------------
module calendar_date_add_days_unit #(
  parameter int OFFSET_BITS = cdad_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave side: date and offset request
  input  logic        s_tvalid,
  output logic        s_tready,
  // [4:0] day_in, [8:5] month_in, [22:9] year_in,
  // [22+OFFSET_BITS:23] day_offset, zero pad to whole bytes
  input  logic [((cdad_pkg::DAY_W + cdad_pkg::MONTH_W + cdad_pkg::YEAR_W
                  + OFFSET_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // master side: resulting date
  output logic        m_tvalid,
  input  logic        m_tready,
  // [4:0] day_out, [8:5] month_out, [22:9] year_out, [23] zero pad
  output logic [23:0] m_tdata,
  // [0] year_overflow
  output logic        m_tuser
);
  import cdad_pkg::*;

  localparam int DW      = OFFSET_BITS + 1;
  localparam int MO_LSB  = DAY_W;
  localparam int YR_LSB  = DAY_W + MONTH_W;
  localparam int OFF_LSB = DAY_W + MONTH_W + YEAR_W;
  localparam int Q_W     = $bits(cdad_date_t) + DW;

  // request fields
  logic [DAY_W-1:0]              day_in;
  logic [MONTH_W-1:0]            month_in;
  logic [YEAR_W-1:0]             year_in;
  logic signed [OFFSET_BITS-1:0] day_offset;

  assign day_in     = s_tdata[DAY_W-1:0];
  assign month_in   = s_tdata[MO_LSB +: MONTH_W];
  assign year_in    = s_tdata[YR_LSB +: YEAR_W];
  assign day_offset = s_tdata[OFF_LSB +: OFFSET_BITS];

  // front end to queue
  logic                  fe_valid;
  logic                  fe_ready;
  cdad_date_t            fe_date;
  logic signed [DW-1:0]  fe_day;

  // queue to roller
  logic                  q_wr;
  logic                  q_rd;
  logic                  q_full;
  logic                  q_empty;
  logic [Q_W-1:0]        q_rdata;
  cdad_date_t            q_date;
  logic signed [DW-1:0]  q_day;

  // result
  logic [DAY_W-1:0]      day_out;
  logic [MONTH_W-1:0]    month_out;
  logic [YEAR_W-1:0]     year_out;
  logic                  year_overflow;

  cdad_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .day_in     (day_in),
    .month_in   (month_in),
    .year_in    (year_in),
    .day_offset (day_offset),
    .out_valid  (fe_valid),
    .out_ready  (fe_ready),
    .out_date   (fe_date),
    .out_day    (fe_day)
  );

  // push whenever the front end holds a request and the queue has room
  assign fe_ready = !q_full;
  assign q_wr     = fe_valid && !q_full;

  cdad_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data ({fe_date, fe_day}),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign q_date = q_rdata[Q_W-1:DW];
  assign q_day  = q_rdata[DW-1:0];

  cdad_roller #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_roller (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_pop         (q_rd),
    .q_date        (q_date),
    .q_day         (q_day),
    .res_valid     (m_tvalid),
    .res_ready     (m_tready),
    .day_out       (day_out),
    .month_out     (month_out),
    .year_out      (year_out),
    .year_overflow (year_overflow)
  );

  assign m_tdata = {1'b0, year_out, month_out, day_out};
  assign m_tuser = year_overflow;

`ifndef NO_ASSERTIONS
  // roller never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_empty)
    else $error("roller popped an empty queue");

  // result date stays within the calendar
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (year_out <= YEAR_MAX) && (month_out >= MONTH_JAN)
                 && (month_out <= MONTH_DEC) && (day_out != '0))
    else $error("result date out of range");

  // a saturated result is one of the two range-end dates
  a_ovf_saturate: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && year_overflow) |->
      ((year_out == YEAR_MAX) && (month_out == MONTH_DEC) && (day_out == DAY_LAST))
      || ((year_out == YEAR_MIN) && (month_out == MONTH_JAN) && (day_out == DAY_FIRST)))
    else $error("overflow flag without saturated date");

  // a queue that is full cannot also be empty
  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue reports full and empty");
`endif

endmodule
